// File: rtl/scsp_pkg.sv
// ----------------------------------------------------------------------------
// scsp_pkg
// Shared constants and types of the system-controller serial command port.
// ----------------------------------------------------------------------------
package scsp_pkg;

  localparam int DEFAULT_BUFFER_BYTES = 16;
  localparam int RESP_BYTES = 8;

  localparam logic [7:0] OFS_CTRL = 8'h04;
  localparam logic [7:0] OFS_DATA = 8'h08;
  localparam logic [7:0] OFS_STAT = 8'h0C;

  localparam logic [7:0] STATUS_BYTE    = 8'h13;
  localparam logic [7:0] SUBSTATUS_BYTE = 8'h82;

  localparam logic [7:0] CMD_RD_CLOCK = 8'h09;
  localparam logic [7:0] CMD_RD_ALARM = 8'h0A;
  localparam logic [7:0] CMD_WR_ALARM = 8'h22;

  localparam logic [2:0] RESP_LEN_SHORT = 3'd3;
  localparam logic [2:0] RESP_LEN_LONG  = 3'd7;

  localparam int CTRL_RUN_BIT    = 1;
  localparam int CTRL_REWIND_BIT = 2;
  localparam int STAT_ALWAYS_BIT = 0;
  localparam int STAT_DATA_BIT   = 2;

  typedef struct packed {
    logic [RESP_BYTES-1:0][7:0] data;
    logic [RESP_BYTES-1:0]      we;
    logic [2:0]                 len;
    logic                       alarm_we;
    logic [31:0]                alarm;
  } resp_t;

endpackage

// File: rtl/syscon_serial_command_port.sv
// ----------------------------------------------------------------------------
// syscon_serial_command_port
// Bus-mapped serial command port: one register access per request in,
// one result per request out.
// ----------------------------------------------------------------------------
// channel   dir  signals                        payload
// s_axis    in   s_axis_tvalid/tready/tdata/tuser  tdata: offset, write_data; tuser: mode
// m_axis    out  m_axis_tvalid/tready/tdata     tdata: read_data, response_ready
//
// One request per cycle sustained while the result is not stalled; a request
// passes through the input register, then the access logic into the result
// register, from which the result can be taken.
// rst is synchronous and clears the buffer, index, alarm and both stages.
// A stalled result holds in the result register; one more request may wait
// in the input register behind it.
// ----------------------------------------------------------------------------
module syscon_serial_command_port #(
  parameter int BUFFER_BYTES = scsp_pkg::DEFAULT_BUFFER_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [7:0] offset, [39:8] write_data
  input  logic        s_axis_tuser,  // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // [31:0] read_data, [32] response_ready, zero pad
);

  logic        s1_valid;
  logic        s1_mode;
  logic [7:0]  s1_offset;
  logic [31:0] s1_wdata;
  logic        advance;
  logic [31:0] rd_data;
  logic        ready;
  logic [31:0] out_rd_data;
  logic        out_ready;

  assign advance       = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || advance;
  assign m_axis_tdata  = {7'd0, out_ready, out_rd_data};

  scsp_regfile #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_regfile (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .mode    (s1_mode),
    .offset  (s1_offset),
    .wdata   (s1_wdata),
    .rd_data (rd_data),
    .ready   (ready)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_mode   <= s_axis_tuser;
      s1_offset <= s_axis_tdata[7:0];
      s1_wdata  <= s_axis_tdata[39:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rd_data <= rd_data;
      out_ready   <= ready;
    end
  end

endmodule

// File: rtl/scsp_resp_build.sv
// ----------------------------------------------------------------------------
// scsp_resp_build
// Builds the response packet bytes, checksum and alarm update for a command.
// ----------------------------------------------------------------------------
module scsp_resp_build (
  input  logic [7:0]      cmd,
  input  logic [31:0]     cmd_args,
  input  logic [31:0]     alarm,
  output scsp_pkg::resp_t resp
);

  logic        is_long;
  logic [31:0] payload;
  logic [7:0]  sum;

  always_comb begin
    is_long = (cmd == scsp_pkg::CMD_RD_CLOCK) || (cmd == scsp_pkg::CMD_RD_ALARM);
    payload = (cmd == scsp_pkg::CMD_RD_ALARM) ? alarm : 32'd0;

    resp.len      = is_long ? scsp_pkg::RESP_LEN_LONG : scsp_pkg::RESP_LEN_SHORT;
    resp.alarm_we = (cmd == scsp_pkg::CMD_WR_ALARM);
    resp.alarm    = cmd_args;

    sum = scsp_pkg::STATUS_BYTE + {5'd0, resp.len} + scsp_pkg::SUBSTATUS_BYTE;
    if (is_long) begin
      sum = sum + payload[7:0] + payload[15:8] + payload[23:16] + payload[31:24];
    end

    resp.data[0] = scsp_pkg::STATUS_BYTE;
    resp.data[1] = {5'd0, resp.len};
    resp.data[2] = scsp_pkg::SUBSTATUS_BYTE;
    if (is_long) begin
      resp.data[3] = payload[7:0];
      resp.data[4] = payload[15:8];
      resp.data[5] = payload[23:16];
      resp.data[6] = payload[31:24];
      resp.data[7] = ~sum;
      resp.we      = '1;
    end else begin
      resp.data[3] = ~sum;
      resp.data[4] = 8'd0;
      resp.data[5] = 8'd0;
      resp.data[6] = 8'd0;
      resp.data[7] = 8'd0;
      resp.we      = 8'b0000_1111;
    end
  end

endmodule

// File: rtl/scsp_regfile.sv
// ----------------------------------------------------------------------------
// scsp_regfile
// Port state and register access: packet buffer, byte index, alarm, status.
// ----------------------------------------------------------------------------
module scsp_regfile #(
  parameter int BUFFER_BYTES = scsp_pkg::DEFAULT_BUFFER_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        mode,
  input  logic [7:0]  offset,
  input  logic [31:0] wdata,
  output logic [31:0] rd_data,
  output logic        ready
);

  localparam int ROWS      = (BUFFER_BYTES + 1) / 2;
  localparam int IW        = $clog2(BUFFER_BYTES + 1);
  localparam int RW        = $clog2(ROWS);
  localparam int RESP_ROWS = scsp_pkg::RESP_BYTES / 2;

  logic [ROWS-1:0][15:0] rows;
  logic [ROWS-1:0][15:0] rows_next;
  logic [IW-1:0]         idx;
  logic [IW-1:0]         idx_next;
  logic [2:0]            resp_len;
  logic [2:0]            resp_len_next;
  logic                  exhausted;
  logic                  exhausted_next;
  logic [31:0]           alarm;
  logic [31:0]           alarm_next;

  scsp_pkg::resp_t resp;

  logic          ctrl_wr;
  logic          run;
  logic          data_wr;
  logic          data_rd;
  logic          stat_rd;
  logic          in_range;
  logic          wr_ok;
  logic [RW-1:0] row_sel;
  logic [15:0]   rd_row;
  logic [IW:0]   idx_sum;
  logic [IW-1:0] idx_adv;

  scsp_resp_build u_resp_build (
    .cmd      (rows[0][15:8]),
    .cmd_args ({rows[2][7:0], rows[2][15:8], rows[1][7:0], rows[1][15:8]}),
    .alarm    (alarm),
    .resp     (resp)
  );

  always_comb begin
    ctrl_wr  = en && mode && (offset == scsp_pkg::OFS_CTRL);
    run      = ctrl_wr && wdata[scsp_pkg::CTRL_RUN_BIT];
    data_wr  = en && mode && (offset == scsp_pkg::OFS_DATA);
    data_rd  = en && !mode && (offset == scsp_pkg::OFS_DATA);
    stat_rd  = en && !mode && (offset == scsp_pkg::OFS_STAT);
    in_range = idx < IW'(BUFFER_BYTES);
    wr_ok    = ((IW+1)'(idx) + (IW+1)'(1)) < (IW+1)'(BUFFER_BYTES);
    row_sel  = idx[RW:1];
    rd_row   = in_range ? rows[row_sel] : 16'd0;
    idx_sum  = (IW+1)'(idx) + (IW+1)'(2);
    idx_adv  = (idx_sum > (IW+1)'(BUFFER_BYTES)) ? IW'(BUFFER_BYTES) : idx_sum[IW-1:0];
  end

  always_comb begin
    rows_next      = rows;
    idx_next       = idx;
    resp_len_next  = resp_len;
    exhausted_next = exhausted;
    alarm_next     = alarm;
    if (ctrl_wr && wdata[scsp_pkg::CTRL_REWIND_BIT]) begin
      idx_next = '0;
    end
    if (run) begin
      for (int r = 0; r < RESP_ROWS; r++) begin
        if (resp.we[2*r]) begin
          rows_next[r][15:8] = resp.data[2*r];
        end
        if (resp.we[2*r+1]) begin
          rows_next[r][7:0] = resp.data[2*r+1];
        end
      end
      if (resp.alarm_we) begin
        alarm_next = resp.alarm;
      end
      idx_next       = '0;
      resp_len_next  = resp.len;
      exhausted_next = 1'b0;
    end
    if (data_wr) begin
      if (wr_ok) begin
        rows_next[row_sel] = wdata[15:0];
      end
      idx_next = idx_adv;
    end
    if (data_rd) begin
      if (idx_adv > IW'(resp_len)) begin
        idx_next       = '0;
        exhausted_next = 1'b1;
      end else begin
        idx_next = idx_adv;
      end
    end
  end

  always_comb begin
    rd_data = 32'd0;
    if (data_rd) begin
      rd_data = {16'd0, rd_row};
    end else if (stat_rd) begin
      rd_data[scsp_pkg::STAT_ALWAYS_BIT] = 1'b1;
      rd_data[scsp_pkg::STAT_DATA_BIT]   = !exhausted;
    end
    ready = run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows      <= '0;
      idx       <= '0;
      resp_len  <= '0;
      exhausted <= 1'b1;
      alarm     <= '0;
    end else begin
      rows      <= rows_next;
      idx       <= idx_next;
      resp_len  <= resp_len_next;
      exhausted <= exhausted_next;
      alarm     <= alarm_next;
    end
  end

endmodule

// File: test/tb_syscon_serial_command_port.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_syscon_serial_command_port
// Drives register reads and writes into the serial command port and checks
// every reply against a cycle-free model of the packet buffer, index, alarm
// and response builder. Directed accesses come first, then command sequences
// with random content, with noise mixed in, under four sender/receiver idling
// phases.
// ----------------------------------------------------------------------------
module tb_syscon_serial_command_port;

  localparam int BUF_BYTES      = scsp_pkg::DEFAULT_BUFFER_BYTES;
  localparam int PHASE_REQUESTS = 450;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [31:0] rdata;
    logic        ready;
  } reply_t;

  class reply_tracker;
    logic [7:0]  pkt [BUF_BYTES];
    int unsigned idx;
    logic [2:0]  resp_len;
    bit          drained;
    logic [31:0] alarm;
    reply_t      pending [$];
    int          mismatches;
    int          requests;
    int          commands;
    int          replies;

    function new();
      foreach (pkt[i]) pkt[i] = 8'h00;
      idx        = 0;
      resp_len   = 3'd0;
      drained    = 1'b1;
      alarm      = 32'h0;
      mismatches = 0;
      requests   = 0;
      commands   = 0;
      replies    = 0;
    endfunction

    function logic [7:0] peek(int unsigned pos);
      return (pos < BUF_BYTES) ? pkt[pos] : 8'h00;
    endfunction

    function void poke(int unsigned pos, logic [7:0] v);
      if (pos < BUF_BYTES) pkt[pos] = v;
    endfunction

    function void bump_index();
      idx += 2;
      if (idx > BUF_BYTES) idx = BUF_BYTES;
    endfunction

    function void build_response();
      logic [7:0]  cmd;
      logic [7:0]  payload [5];
      int unsigned plen;
      int unsigned len;
      logic [7:0]  sum;
      logic [31:0] v;
      cmd        = peek(0);
      plen       = 1;
      sum        = 8'h00;
      v          = 32'h0;
      payload[0] = scsp_pkg::SUBSTATUS_BYTE;
      for (int i = 1; i < 5; i++) payload[i] = 8'h00;
      case (cmd)
        scsp_pkg::CMD_RD_CLOCK: plen = 5;
        scsp_pkg::CMD_RD_ALARM: begin
          for (int i = 0; i < 4; i++) payload[1+i] = alarm[8*i +: 8];
          plen = 5;
        end
        scsp_pkg::CMD_WR_ALARM: begin
          for (int i = 0; i < 4; i++) v[8*i +: 8] = peek(2 + i);
          alarm = v;
        end
        default: ;
      endcase
      len = plen + 2;
      poke(0, scsp_pkg::STATUS_BYTE);
      poke(1, len[7:0]);
      for (int unsigned i = 0; i < plen; i++) poke(2 + i, payload[i]);
      for (int unsigned i = 0; i < len; i++) sum = sum + peek(i);
      poke(len, ~sum);
      idx      = 0;
      resp_len = len[2:0];
      drained  = 1'b0;
      commands++;
    endfunction

    function void note_request(bit wr, logic [7:0] ofs, logic [31:0] wd);
      reply_t r;
      r = '0;
      requests++;
      if (wr) begin
        if (ofs == scsp_pkg::OFS_CTRL) begin
          if (wd[scsp_pkg::CTRL_REWIND_BIT]) idx = 0;
          if (wd[scsp_pkg::CTRL_RUN_BIT]) begin
            build_response();
            r.ready = 1'b1;
          end
        end else if (ofs == scsp_pkg::OFS_DATA) begin
          if (idx + 1 < BUF_BYTES) begin
            pkt[idx]   = wd[15:8];
            pkt[idx+1] = wd[7:0];
          end
          bump_index();
        end
      end else if (ofs == scsp_pkg::OFS_DATA) begin
        r.rdata = {16'h0000, peek(idx), peek(idx + 1)};
        bump_index();
        if (idx > resp_len) begin
          idx     = 0;
          drained = 1'b1;
        end
      end else if (ofs == scsp_pkg::OFS_STAT) begin
        r.rdata[scsp_pkg::STAT_ALWAYS_BIT] = 1'b1;
        r.rdata[scsp_pkg::STAT_DATA_BIT]   = !drained;
      end
      pending.push_back(r);
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("mismatch: %s", msg);
    endfunction

    function void check_reply(logic [39:0] tdata);
      reply_t e;
      replies++;
      if (pending.size() == 0) begin
        note_mismatch($sformatf("reply %0d with none pending, tdata %h", replies, tdata));
        return;
      end
      e = pending.pop_front();
      if (tdata[31:0] !== e.rdata || tdata[32] !== e.ready)
        note_mismatch($sformatf("reply %0d: read_data exp %h got %h, ready exp %0b got %0b",
                                replies, e.rdata, tdata[31:0], e.ready, tdata[32]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // [7:0] offset, [39:8] write_data
  logic        s_axis_tuser = 1'b0;  // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;  // [31:0] read_data, [32] response_ready, zero pad

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int cycles         = 0;
  int n_sent         = 0;

  reply_tracker tracker;

  syscon_serial_command_port i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL syscon_serial_command_port");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) tracker.check_reply(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic send_request(bit wr, logic [7:0] ofs, logic [31:0] wd);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {wd, ofs};
    s_axis_tuser  <= wr;
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_request(wr, ofs, wd);
    n_sent++;
  endtask

  task automatic wr_reg(logic [7:0] ofs, logic [31:0] wd);
    send_request(1'b1, ofs, wd);
  endtask

  task automatic rd_reg(logic [7:0] ofs);
    send_request(1'b0, ofs, $urandom());
  endtask

  task automatic run_command_sequence();
    logic [7:0]  cmd;
    logic [31:0] wd;
    int          nwr;
    int          nrd;
    case ($urandom_range(3))
      0:       cmd = scsp_pkg::CMD_RD_CLOCK;
      1:       cmd = scsp_pkg::CMD_RD_ALARM;
      2:       cmd = scsp_pkg::CMD_WR_ALARM;
      default: cmd = 8'($urandom_range(255));
    endcase
    nwr = ($urandom_range(9) == 0) ? $urandom_range(4, 9) : $urandom_range(1, 3);
    nrd = $urandom_range(0, 6);
    // rewind first, but sometimes skip it to land on a stale index
    if ($urandom_range(7) != 0) begin
      wd = $urandom();
      wd[scsp_pkg::CTRL_REWIND_BIT] = 1'b1;
      wd[scsp_pkg::CTRL_RUN_BIT]    = 1'b0;
      wr_reg(scsp_pkg::OFS_CTRL, wd);
    end
    for (int i = 0; i < nwr; i++) begin
      wd = $urandom();
      if (i == 0) wd[15:8] = cmd;
      wr_reg(scsp_pkg::OFS_DATA, wd);
    end
    if ($urandom_range(15) != 0) begin
      wd = $urandom();
      wd[scsp_pkg::CTRL_RUN_BIT] = 1'b1;
      wr_reg(scsp_pkg::OFS_CTRL, wd);
    end
    for (int i = 0; i < nrd; i++) begin
      rd_reg(($urandom_range(3) == 0) ? scsp_pkg::OFS_STAT : scsp_pkg::OFS_DATA);
    end
  endtask

  task automatic send_noise();
    logic [7:0] ofs;
    case ($urandom_range(7))
      0:       ofs = 8'h00;
      1:       ofs = scsp_pkg::OFS_CTRL;
      2:       ofs = scsp_pkg::OFS_DATA;
      3:       ofs = scsp_pkg::OFS_STAT;
      default: ofs = 8'($urandom_range(255));
    endcase
    send_request(1'($urandom_range(1)), ofs, $urandom());
  endtask

  initial begin
    tracker = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    rd_reg(scsp_pkg::OFS_STAT);
    rd_reg(scsp_pkg::OFS_DATA);
    rd_reg(scsp_pkg::OFS_CTRL);
    rd_reg(8'hFF);
    wr_reg(scsp_pkg::OFS_STAT, 32'hFFFF_FFFF);
    wr_reg(8'h00, 32'hFFFF_FFFF);
    wr_reg(scsp_pkg::OFS_CTRL, 32'hFFFF_FFF9);
    // write alarm, then read the short response back to its end
    wr_reg(scsp_pkg::OFS_CTRL, 32'h0000_0004);
    wr_reg(scsp_pkg::OFS_DATA, {16'h0000, scsp_pkg::CMD_WR_ALARM, 8'h00});
    wr_reg(scsp_pkg::OFS_DATA, 32'h0000_1234);
    wr_reg(scsp_pkg::OFS_DATA, 32'hFFFF_5678);
    wr_reg(scsp_pkg::OFS_CTRL, 32'h0000_0002);
    rd_reg(scsp_pkg::OFS_STAT);
    rd_reg(scsp_pkg::OFS_DATA);
    rd_reg(scsp_pkg::OFS_DATA);
    rd_reg(scsp_pkg::OFS_STAT);
    // read alarm with a long response
    wr_reg(scsp_pkg::OFS_CTRL, 32'h0000_0004);
    wr_reg(scsp_pkg::OFS_DATA, {16'h0000, scsp_pkg::CMD_RD_ALARM, 8'h00});
    wr_reg(scsp_pkg::OFS_CTRL, 32'h0000_0002);
    repeat (4) rd_reg(scsp_pkg::OFS_DATA);
    // rewind and run on a stale buffer: unknown command
    wr_reg(scsp_pkg::OFS_CTRL, 32'h0000_0006);
    rd_reg(scsp_pkg::OFS_DATA);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 80; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 80; end
        default: begin src_idle_pct = 7; sink_stall_pct = 7; end
      endcase
      while (n_sent < (phase + 1) * PHASE_REQUESTS) begin
        if ($urandom_range(3) == 0) begin
          repeat ($urandom_range(1, 3)) send_noise();
        end else begin
          run_command_sequence();
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d command runs; %0d replies checked, %0d mismatches",
             tracker.requests, tracker.commands, tracker.replies, tracker.mismatches);
    $display("phases: free running, sender idle, receiver stalled, both lightly throttled");
    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("PASS syscon_serial_command_port");
    end else begin
      $display("FAIL syscon_serial_command_port");
    end
    $finish;
  end

endmodule
